@@ rtl/bitmap_page_frame_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Bitmap page frame allocator - assertion macros
// Short forms for clocked implications with the reset disable built in.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfa assertion failed");

// next-cycle implication
`define BPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpfa assertion failed");

`endif

@@ rtl/bpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types and constants shared by the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int NUM_BLOCKS_DEF      = 1024;
    localparam int BLOCK_SHIFT_DEF     = 12;
    localparam int RESERVED_BLOCKS_DEF = 10;

    localparam int ADDR_W = 32;
    localparam int WORD_W = 32;   // map bits per memory word
    localparam int BIT_W  = 5;    // bit index within a word

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_CHECK  = 2'd2;
    localparam logic [1:0] FUNC_REINIT = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
    } bpfa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              success;
        logic              in_use;
    } bpfa_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC_WR,
        ST_LOOKUP
    } bpfa_state_t;

    typedef enum logic {
        WU_SET,
        WU_CLEAR
    } wu_op_t;

    typedef struct packed {
        wu_op_t           op;
        logic [BIT_W-1:0] sel;
    } wu_ctl_t;

    typedef struct packed {
        logic             found;    // word has a clear bit
        logic [BIT_W-1:0] ffz;      // lowest clear bit
        logic             bit_val;  // value of the selected bit
    } wu_stat_t;

endpackage

@@ rtl/bpfa_ram.sv @@
// ----------------------------------------------------------------------------
// bpfa_ram
// Single-port-write, single-port-read map memory with registered read data.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/bpfa_word_unit.sv @@
// ----------------------------------------------------------------------------
// bpfa_word_unit
// Shared word operator: first-clear-bit search, bit test and bit update.
// ----------------------------------------------------------------------------
module bpfa_word_unit
    import bpfa_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  wu_ctl_t           ctl,
    output wu_stat_t          stat,
    output logic [WORD_W-1:0] new_word
);

    logic [WORD_W-1:0] mask;

    always_comb
    begin
        stat.ffz = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                stat.ffz = BIT_W'(i);
            end
        end
        stat.found   = ~&word;
        stat.bit_val = word[ctl.sel];
    end

    assign mask     = WORD_W'(1) << ctl.sel;
    assign new_word = (ctl.op == WU_SET) ? (word | mask) : (word & ~mask);

endmodule

@@ rtl/bpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: map clearing sweep, word-by-word allocation scan, and the
// read-modify-write used by free, and the bit read used by check.
// ----------------------------------------------------------------------------
module bpfa_ctrl
    import bpfa_pkg::*;
#(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int BLOCK_SHIFT     = BLOCK_SHIFT_DEF,
    parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
    localparam int NW    = (NUM_BLOCKS + WORD_W - 1) / WORD_W,
    localparam int WA_W  = (NW > 1) ? $clog2(NW) : 1,
    localparam int CNT_W = $clog2(NW + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bpfa_in_t          cmd,
    output logic              busy,
    output logic              done,
    output bpfa_out_t         result,
    output logic              ram_rd_en,
    output logic [WA_W-1:0]   ram_rd_addr,
    output logic              ram_wr_en,
    output logic [WA_W-1:0]   ram_wr_addr,
    output logic [WORD_W-1:0] ram_wr_data,
    output wu_ctl_t           wu_ctl,
    input  wu_stat_t          wu_stat,
    input  logic [WORD_W-1:0] wu_word
);

    bpfa_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [WA_W-1:0]   word_reg, word_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              is_check_reg, is_check_next;
    logic              report_reg, report_next;
    logic              done_reg, done_next;
    bpfa_out_t         result_reg, result_next;

    logic [ADDR_W-1:0] blk_idx;
    logic              in_range;
    logic              clear_last;
    logic              scan_end;
    logic [WORD_W-1:0] init_word;
    logic [ADDR_W-1:0] alloc_addr;

    assign blk_idx    = cmd.address >> BLOCK_SHIFT;
    assign in_range   = blk_idx < ADDR_W'(NUM_BLOCKS);
    assign clear_last = ptr_reg == CNT_W'(NW - 1);
    assign scan_end   = ptr_reg == CNT_W'(NW);
    assign alloc_addr = ADDR_W'({word_reg, bit_reg}) << BLOCK_SHIFT;

    // reserved blocks and padding past the last block read as used
    always_comb
    begin
        int blk;
        for (int b = 0; b < WORD_W; b++)
        begin
            blk = int'(ptr_reg) * WORD_W + b;
            init_word[b] = (blk < RESERVED_BLOCKS) || (blk >= NUM_BLOCKS);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        FUNC_ALLOC:  state_next = ST_SCAN;
                        FUNC_REINIT: state_next = ST_CLEAR;
                        default:     state_next = in_range ? ST_LOOKUP : ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (wu_stat.found)
                begin
                    state_next = ST_ALLOC_WR;
                end
                else if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC_WR: state_next = ST_IDLE;
            ST_LOOKUP:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ptr_next      = ptr_reg;
        word_next     = word_reg;
        bit_next      = bit_reg;
        is_check_next = is_check_reg;
        report_next   = report_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = word_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = word_reg;
        ram_wr_data   = wu_word;
        wu_ctl.op     = WU_SET;
        wu_ctl.sel    = bit_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg[WA_W-1:0];
                ram_wr_data = init_word;
                ptr_next    = ptr_reg + CNT_W'(1);
                if (clear_last)
                begin
                    done_next   = report_reg;
                    report_next = 1'b0;
                    result_next = '{block_address: '0, success: 1'b1, in_use: 1'b0};
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        FUNC_ALLOC:
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            word_next   = '0;
                            ptr_next    = CNT_W'(1);
                        end
                        FUNC_REINIT:
                        begin
                            ptr_next    = '0;
                            report_next = 1'b1;
                        end
                        default:
                        begin
                            if (in_range)
                            begin
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = blk_idx[WA_W+BIT_W-1:BIT_W];
                                word_next     = blk_idx[WA_W+BIT_W-1:BIT_W];
                                bit_next      = blk_idx[BIT_W-1:0];
                                is_check_next = cmd.func == FUNC_CHECK;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{block_address: '0, success: 1'b0,
                                                in_use: 1'b0};
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // word_reg names the word now on the read port
                if (wu_stat.found)
                begin
                    bit_next = wu_stat.ffz;
                end
                else if (scan_end)
                begin
                    done_next   = 1'b1;
                    result_next = '{block_address: '0, success: 1'b0, in_use: 1'b0};
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg[WA_W-1:0];
                    word_next   = ptr_reg[WA_W-1:0];
                    ptr_next    = ptr_reg + CNT_W'(1);
                end
            end
            ST_ALLOC_WR:
            begin
                ram_wr_en   = 1'b1;
                done_next   = 1'b1;
                result_next = '{block_address: alloc_addr, success: 1'b1, in_use: 1'b0};
            end
            ST_LOOKUP:
            begin
                wu_ctl.op   = WU_CLEAR;
                ram_wr_en   = !is_check_reg;
                done_next   = 1'b1;
                result_next = '{block_address: '0, success: 1'b1,
                                in_use: is_check_reg & wu_stat.bit_val};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            report_reg   <= 1'b0;
            done_reg     <= 1'b0;
            is_check_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            report_reg   <= report_next;
            done_reg     <= done_next;
            is_check_reg <= is_check_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        bit_reg    <= bit_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a one-bit-per-block in-use map.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its single
// result is shown for one cycle with done high and must be captured then.
// The map sits in a memory of 32-bit words (NW = ceil(NUM_BLOCKS/32) words,
// 32 at defaults) with one read and one write port. Allocate reads the map
// one word read per cycle through the shared search unit until a free bit
// is found, at most NW words, and fails on a full map. Free and check in
// range read the addressed word; out of range they answer from idle with
// no read. After reset, and on reinitialize, the block is busy while it
// writes the reserved pattern into the map.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int BLOCK_SHIFT     = BLOCK_SHIFT_DEF,
    parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bpfa_in_t  cmd,
    output logic      busy,
    output logic      done,
    output bpfa_out_t result
);

    localparam int NW   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WA_W = (NW > 1) ? $clog2(NW) : 1;

    logic              ram_rd_en;
    logic [WA_W-1:0]   ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;
    logic              ram_wr_en;
    logic [WA_W-1:0]   ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    wu_ctl_t           wu_ctl;
    wu_stat_t          wu_stat;
    logic [WORD_W-1:0] wu_word;

    bpfa_ctrl #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .BLOCK_SHIFT     (BLOCK_SHIFT),
        .RESERVED_BLOCKS (RESERVED_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .wu_ctl      (wu_ctl),
        .wu_stat     (wu_stat),
        .wu_word     (wu_word)
    );

    bpfa_ram #(
        .DEPTH (NW),
        .AW    (WA_W),
        .DW    (WORD_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    bpfa_word_unit u_word_unit (
        .word     (ram_rd_data),
        .ctl      (wu_ctl),
        .stat     (wu_stat),
        .new_word (wu_word)
    );

endmodule

@@ rtl/bpfa_checker.sv @@
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level checks on the allocator's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_assert.svh"

module bpfa_checker
    import bpfa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input bpfa_out_t result
);

    // a taken command either keeps the block busy or answers at once
    `BPFA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    `BPFA_ASSERT_NOW(a_in_use_ok, done && result.in_use, result.success)
    `BPFA_ASSERT_NOW(a_addr_ok, done && result.block_address != '0, result.success)
    `BPFA_ASSERT_NOW(a_check_no_addr, done && result.in_use, result.block_address == '0)

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
